// ===== sv/tlcb_pkg.sv =====
// shared types and constants for the thick line and disc rasterizer
`timescale 1ns / 1ps
package tlcb_pkg;
    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;
    localparam int COLOR_BITS   = 8;
    localparam int MAX_RADIUS   = 15;
    localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(PIXEL_COUNT);
    localparam int COORD_W      = 12;
    localparam int RAD_W        = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;

    localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
    localparam logic [1:0] CMD_FILL_DISC = 2'd1;
    localparam logic [1:0] CMD_DRAW_LINE = 2'd2;
    localparam logic [1:0] CMD_READ_PIX  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture a new beat
        logic clr_step;    // clear address of the clearing pass
        logic clr_write;   // write zero at clear address
        logic line_init;   // order endpoints, set first major step
        logic div_start;   // start minor coordinate division
        logic div_step;    // one quotient bit
        logic disc_init;   // set disc offset to the top left corner
        logic disc_center; // move disc center to the current line step
        logic disc_step;   // test and write one disc pixel, advance offset
        logic major_step;  // next major step
        logic pix_write;   // single pixel write
        logic rd_issue;    // read address to memory
        logic rd_capture;  // latch read data into result
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic disc_last;
        logic line_last;
    } t_stat;
endpackage

// ===== sv/tlcb_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module tlcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== sv/tlcb_datapath.sv =====
// coordinates, divider, disc walker and frame memory
`timescale 1ns / 1ps
module tlcb_datapath import tlcb_pkg::*; (
    input  logic                      i_clk,
    input  t_ctrl                     i_ctrl,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic [3:0]                i_brush_radius,
    input  logic [7:0]                i_paint_color,
    output t_stat                     o_stat,
    output logic [7:0]                o_pixel_value,
    output logic                      o_pixel_inside
);
    localparam int W  = 14;          // coordinate arithmetic width
    localparam int QW = 26;          // product and quotient width
    localparam int QCW = $clog2(QW + 1);

    logic signed [W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [RAD_W-1:0]    r_rad;
    logic [COLOR_BITS-1:0] r_color;
    logic                r_steep;
    logic signed [W-1:0] r_maj;      // current major coordinate
    logic signed [W-1:0] r_cx, r_cy; // disc center
    logic signed [W-1:0] r_dx, r_dy;
    logic [ADDR_W:0]     r_clr;
    // divider
    logic [QW-1:0]       r_num, r_quo;
    logic [QW:0]         r_rem;
    logic [W-1:0]        r_den;
    logic                r_neg;
    logic [QCW-1:0]      r_cnt;
    logic [7:0]          r_value;
    logic                r_inside;

    // wider signed forms of inputs
    logic signed [W-1:0] w_sx, w_sy, w_ex, w_ey, w_adx, w_ady;
    assign w_sx = W'(i_start_x);
    assign w_sy = W'(i_start_y);
    assign w_ex = W'(i_end_x);
    assign w_ey = W'(i_end_y);
    assign w_adx = (r_x1 > r_x0) ? r_x1 - r_x0 : r_x0 - r_x1;
    assign w_ady = (r_y1 > r_y0) ? r_y1 - r_y0 : r_y0 - r_y1;

    logic w_steep, w_swap;
    assign w_steep = w_adx < w_ady;
    assign w_swap  = w_steep ? (r_y0 > r_y1) : (r_x0 > r_x1);

    // ordered endpoints as major a and minor b
    logic signed [W-1:0] w_a0, w_a1, w_b0, w_b1;
    assign w_a0 = r_steep ? r_y0 : r_x0;
    assign w_a1 = r_steep ? r_y1 : r_x1;
    assign w_b0 = r_steep ? r_x0 : r_y0;
    assign w_b1 = r_steep ? r_x1 : r_y1;

    // numerator for the current step
    logic signed [W-1:0]  w_di, w_db;
    logic signed [QW-1:0] w_prod;
    assign w_di   = r_maj - w_a0;
    assign w_db   = w_b1 + 14'sd1 - w_b0;
    assign w_prod = QW'(w_di) * QW'(w_db);

    // restoring divider, one bit a cycle
    logic [QW:0] w_rsh;
    logic [QW:0] w_trial;
    assign w_rsh   = {r_rem[QW-1:0], r_num[QW-1]};
    assign w_trial = w_rsh - (QW+1)'(r_den);

    logic signed [QW-1:0] w_q;
    logic signed [W-1:0]  w_minor;
    assign w_q     = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign w_minor = W'(w_q) + w_b0;

    // disc test
    logic [2*W-1:0] w_d2, w_r2;
    assign w_d2 = (2*W)'(r_dx * r_dx) + (2*W)'(r_dy * r_dy);
    assign w_r2 = (2*W)'(r_rad) * (2*W)'(r_rad);
    logic signed [W-1:0] w_rs;
    assign w_rs = W'(r_rad);

    logic signed [W-1:0] w_px, w_py;
    logic w_in;
    always_comb begin
        if (i_ctrl.pix_write || i_ctrl.rd_issue) begin
            w_px = r_cx;
            w_py = r_cy;
        end else begin
            w_px = r_cx + r_dx;
            w_py = r_cy + r_dy;
        end
    end
    assign w_in = (w_px >= 0) && (w_px < W'(FRAME_WIDTH))
               && (w_py >= 0) && (w_py < W'(FRAME_HEIGHT));

    logic [ADDR_W-1:0]     w_addr;
    logic                  w_we;
    logic [COLOR_BITS-1:0] w_wdata, w_rdata;
    always_comb begin
        if (i_ctrl.clr_write) begin
            w_addr  = r_clr[ADDR_W-1:0];
            w_we    = 1'b1;
            w_wdata = '0;
        end else begin
            w_addr  = ADDR_W'(w_py * W'(FRAME_WIDTH) + w_px);
            w_we    = w_in && (i_ctrl.pix_write
                      || (i_ctrl.disc_step && (w_d2 <= w_r2)));
            w_wdata = r_color;
        end
    end

    tlcb_ram #(.WIDTH(COLOR_BITS), .DEPTH(PIXEL_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_step) begin
            r_clr <= '0;
        end else if (i_ctrl.clr_write) begin
            r_clr <= r_clr + 1'b1;
        end
        if (i_ctrl.load) begin
            r_x0    <= w_sx;
            r_y0    <= w_sy;
            r_x1    <= w_ex;
            r_y1    <= w_ey;
            r_cx    <= w_sx;
            r_cy    <= w_sy;
            r_rad   <= (32'(i_brush_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                          : RAD_W'(i_brush_radius);
            r_color <= COLOR_BITS'(i_paint_color);
            r_value <= '0;
            r_inside <= 1'b0;
        end
        if (i_ctrl.line_init) begin
            r_steep <= w_steep;
            if (w_swap) begin
                r_x0 <= r_x1; r_x1 <= r_x0;
                r_y0 <= r_y1; r_y1 <= r_y0;
                r_maj <= w_steep ? r_y1 : r_x1;
            end else begin
                r_maj <= w_steep ? r_y0 : r_x0;
            end
        end
        if (i_ctrl.div_start) begin
            r_neg <= w_prod[QW-1];
            r_num <= w_prod[QW-1] ? QW'(-w_prod) : QW'(w_prod);
            r_den <= W'(w_a1 + 14'sd1 - w_a0);
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_ctrl.div_step) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (!w_trial[QW]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
        if (i_ctrl.disc_init) begin
            r_dx <= -w_rs;
            r_dy <= -w_rs;
            if (i_ctrl.disc_center) begin
                if (r_steep) begin
                    r_cx <= w_minor;
                    r_cy <= r_maj;
                end else begin
                    r_cx <= r_maj;
                    r_cy <= w_minor;
                end
            end
        end else if (i_ctrl.disc_step) begin
            if (r_dx == w_rs) begin
                r_dx <= -w_rs;
                r_dy <= r_dy + 1'b1;
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
        if (i_ctrl.major_step) begin
            r_maj <= r_maj + 1'b1;
        end
        if (i_ctrl.rd_issue) begin
            r_inside <= w_in;
        end
        if (i_ctrl.rd_capture) begin
            r_value <= r_inside ? 8'(w_rdata) : 8'd0;
        end
    end

    assign o_stat.clr_done  = (r_clr == (ADDR_W+1)'(PIXEL_COUNT - 1));
    assign o_stat.div_done  = (r_cnt == QCW'(QW - 1));
    assign o_stat.disc_last = (r_dx == w_rs) && (r_dy == w_rs);
    assign o_stat.line_last = (r_maj == w_a1);
    assign o_pixel_value    = r_value;
    assign o_pixel_inside   = r_inside;
endmodule

// ===== sv/tlcb_ctrl.sv =====
// command sequencer for the rasterizer
`timescale 1ns / 1ps
module tlcb_ctrl import tlcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_LINIT = 4'd3;
    localparam logic [3:0] S_DSTRT = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DISC  = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_RCAP  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_cmd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctrl.clr_write = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd)
                    CMD_SET_PIXEL: begin
                        o_ctrl.pix_write = 1'b1;
                        n_state = S_OUT;
                    end
                    CMD_FILL_DISC: begin
                        o_ctrl.disc_init = 1'b1;
                        n_state = S_DISC;
                    end
                    CMD_DRAW_LINE: n_state = S_LINIT;
                    default: begin
                        o_ctrl.rd_issue = 1'b1;
                        n_state = S_RCAP;
                    end
                endcase
            end
            S_LINIT: begin
                o_ctrl.line_init = 1'b1;
                n_state = S_DSTRT;
            end
            S_DSTRT: begin
                o_ctrl.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_ctrl.disc_init   = 1'b1;
                o_ctrl.disc_center = 1'b1;
                n_state = S_DISC;
            end
            S_DISC: begin
                o_ctrl.disc_step = 1'b1;
                if (i_stat.disc_last) begin
                    if (r_cmd == CMD_DRAW_LINE && !i_stat.line_last) begin
                        o_ctrl.major_step = 1'b1;
                        n_state = S_DSTRT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RCAP: begin
                o_ctrl.rd_capture = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
        if (o_ctrl.load) begin
            r_cmd <= i_command;
        end
    end
endmodule

// ===== sv/thick_line_circle_brush_raster_core.sv =====
// top level of the thick line and filled disc rasterizer
`timescale 1ns / 1ps
// usage:
// input channel i_valid/o_ready carries one command beat: set pixel, fill
// disc, draw thick line or read pixel, with coordinates, brush radius and color
// output channel o_valid/i_ready returns exactly one beat per command:
// the read color and inside flag for a read, zeros for the others
// one command is worked at a time; the input is ready again only after the
// result beat has been taken
// a disc tests all (2r+1)^2 offsets of its bounding square; a line runs the
// one bit per cycle divider and then a disc of (2r+1)^2 pixels at each major
// step; all writes go through the single memory write port
// after reset a clearing pass writes zero to all 4096 pixels, one per cycle,
// and no command is accepted until it ends
// a stalled receiver simply holds the result beat; no work is lost
module thick_line_circle_brush_raster_core import tlcb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_command,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic [3:0]                i_brush_radius,
    input  logic [7:0]                i_paint_color,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_pixel_value,
    output logic                      o_pixel_inside
);
    t_ctrl w_ctrl;
    t_ctrl w_ctrl_dp;
    t_stat w_stat;

    // datapath idles in reset and rewinds the clear address
    always_comb begin
        w_ctrl_dp = w_ctrl;
        if (!i_rst_n) begin
            w_ctrl_dp = '0;
            w_ctrl_dp.clr_step = 1'b1;
        end
    end

    tlcb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_command(i_command),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl)
    );

    tlcb_datapath u_dp (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl_dp),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_brush_radius(i_brush_radius),
        .i_paint_color (i_paint_color),
        .o_stat        (w_stat),
        .o_pixel_value (o_pixel_value),
        .o_pixel_inside(o_pixel_inside)
    );
endmodule

// ===== sv/tlcb_checker.sv =====
// port level checks for the rasterizer, bound to the top level
`timescale 1ns / 1ps
module tlcb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pixel_value,
    input logic       o_pixel_inside
);
    // one command at a time: never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    // a result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_value)
        && $stable(o_pixel_inside)) else $error("result changed in stall");
    // outside reads report zero color
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_inside |-> o_pixel_value == 8'd0)
        else $error("nonzero value outside");
    // accepting a command drops ready next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready after accept");
endmodule

bind thick_line_circle_brush_raster_core tlcb_checker u_tlcb_checker (.*);

// ===== dv/tb.sv =====
// testbench for the thick line and filled disc rasterizer core
`timescale 1ns / 1ps
module tb;
    import tlcb_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_command;
    logic signed [COORD_W-1:0] i_start_x;
    logic signed [COORD_W-1:0] i_start_y;
    logic signed [COORD_W-1:0] i_end_x;
    logic signed [COORD_W-1:0] i_end_y;
    logic [3:0]                i_brush_radius;
    logic [7:0]                i_paint_color;
    logic                      o_valid;
    logic                      i_ready;
    logic [7:0]                o_pixel_value;
    logic                      o_pixel_inside;

    thick_line_circle_brush_raster_core dut (.*);

    // predicted frame contents and queue of expected read beats
    logic [COLOR_BITS-1:0] shadow_frame [PIXEL_COUNT];
    logic [7:0] exp_value_q [$];
    logic       exp_inside_q [$];
    int  n_err;
    longint cycle;
    bit  out_idle_en;
    bit  in_idle_en;

    // directed rows: cmd, sx, sy, ex, ey, r, color, check, value, inside
    typedef struct {
        logic [1:0] cmd;
        int sx, sy, ex, ey, r, color;
        bit chk;
        int val, ins;
    } t_row;

    localparam int N_DIR = 22;
    t_row dir_rows [N_DIR] = '{
        '{CMD_READ_PIX,  0,  0, 0, 0, 0, 0,   1, 0, 1},
        '{CMD_READ_PIX, 63, 63, 0, 0, 0, 0,   1, 0, 1},
        '{CMD_READ_PIX, 64,  0, 0, 0, 0, 0,   1, 0, 0},
        '{CMD_READ_PIX, -1,  5, 0, 0, 0, 0,   1, 0, 0},
        '{CMD_READ_PIX, -2048, 2047, 0, 0, 0, 0, 1, 0, 0},
        '{CMD_SET_PIXEL, 0, 0, 0, 0, 0, 255,  1, 0, 0},
        '{CMD_READ_PIX,  0, 0, 0, 0, 0, 0,    1, 255, 1},
        '{CMD_SET_PIXEL, 63, 63, -2048, 2047, 15, 170, 1, 0, 0},
        '{CMD_READ_PIX, 63, 63, 0, 0, 0, 0,   1, 170, 1},
        '{CMD_SET_PIXEL, 2047, -2048, 0, 0, 0, 85, 1, 0, 0},
        '{CMD_FILL_DISC, 10, 10, 0, 0, 0, 7,  0, 0, 0},
        '{CMD_FILL_DISC, 32, 32, 0, 0, 15, 33, 0, 0, 0},
        '{CMD_READ_PIX, 47, 32, 0, 0, 0, 0,   0, 0, 0},
        '{CMD_READ_PIX, 43, 43, 0, 0, 0, 0,   0, 0, 0},
        '{CMD_FILL_DISC, 0, 63, 0, 0, 3, 12,  0, 0, 0},
        '{CMD_DRAW_LINE, 2, 2, 20, 20, 1, 90,  0, 0, 0},
        '{CMD_DRAW_LINE, 30, 5, 5, 50, 0, 91,  0, 0, 0},
        '{CMD_DRAW_LINE, 40, 10, 5, 12, 2, 92, 0, 0, 0},
        '{CMD_DRAW_LINE, 5, 60, 60, 40, 0, 93, 0, 0, 0},
        '{CMD_DRAW_LINE, 50, 50, 50, 50, 4, 94, 0, 0, 0},
        '{CMD_DRAW_LINE, -10, 30, 70, 30, 0, 95, 0, 0, 0},
        '{CMD_READ_PIX, 31, 30, 0, 0, 0, 0,    0, 0, 0}
    };

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic void paint_pixel(int x, int y, int color);
        if (x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT)
            shadow_frame[y * FRAME_WIDTH + x] = color[COLOR_BITS-1:0];
    endfunction

    function automatic void paint_disc(int cx, int cy, int r, int color);
        for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++)
                if (dx * dx + dy * dy <= r * r)
                    paint_pixel(cx + dx, cy + dy, color);
    endfunction

    // minor coordinate, truncating division as in C
    function automatic int minor_coord(int i, int a0, int a1, int b0, int b1);
        longint num, den;
        num = longint'(i - a0) * longint'(b1 + 1 - b0);
        den = longint'(a1 + 1 - a0);
        return int'(num / den) + b0;
    endfunction

    function automatic void paint_line(int x0, int y0, int x1, int y1, int r, int color);
        int adx, ady, t;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (adx < ady) begin
            if (y0 > y1) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            for (int i = y0; i <= y1; i++)
                paint_disc(minor_coord(i, y0, y1, x0, x1), i, r, color);
        end else begin
            if (x0 > x1) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            for (int i = x0; i <= x1; i++)
                paint_disc(i, minor_coord(i, x0, x1, y0, y1), r, color);
        end
    endfunction

    // apply one command to the shadow frame and queue its result beat
    function automatic void predict_command(logic [1:0] cmd, int sx, int sy, int ex,
                                            int ey, int r, int color);
        logic [7:0] val;
        logic ins;
        val = '0;
        ins = 1'b0;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        case (cmd)
            CMD_SET_PIXEL: paint_pixel(sx, sy, color);
            CMD_FILL_DISC: paint_disc(sx, sy, r, color);
            CMD_DRAW_LINE: paint_line(sx, sy, ex, ey, r, color);
            default: begin
                if (sx >= 0 && sx < FRAME_WIDTH && sy >= 0 && sy < FRAME_HEIGHT) begin
                    ins = 1'b1;
                    val = 8'(shadow_frame[sy * FRAME_WIDTH + sx]);
                end
            end
        endcase
        exp_value_q.push_back(val);
        exp_inside_q.push_back(ins);
    endfunction

    // drive one beat and hold it until accepted
    task automatic send_beat(logic [1:0] cmd, int sx, int sy, int ex, int ey,
                             int r, int color);
        int gap;
        logic signed [COORD_W-1:0] sx_w, sy_w, ex_w, ey_w;
        sx_w = sx[COORD_W-1:0];
        sy_w = sy[COORD_W-1:0];
        ex_w = ex[COORD_W-1:0];
        ey_w = ey[COORD_W-1:0];
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_start_x      <= sx_w;
        i_start_y      <= sy_w;
        i_end_x        <= ex_w;
        i_end_y        <= ey_w;
        i_brush_radius <= r[3:0];
        i_paint_color  <= color[7:0];
        predict_command(cmd, int'(sx_w), int'(sy_w), int'(ex_w), int'(ey_w), r, color);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // random coordinate: mostly near the frame, sometimes full range
    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 4095) - 2048;
            1:       return $urandom_range(0, 1) ? -2048 : 2047;
            default: return $urandom_range(0, 79) - 8;
        endcase
    endfunction

    // receiver: random stall bursts, compare each beat with oldest expectation
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (out_idle_en && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                stall = $urandom_range(1, 10);
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (exp_value_q.size() == 0) begin
                    $display("%0t: result beat with no command outstanding", $time);
                    n_err++;
                end else begin
                    if (o_pixel_value !== exp_value_q[0]) begin
                        $display("%0t: pixel_value expected %0d actual %0d",
                                 $time, exp_value_q[0], o_pixel_value);
                        n_err++;
                    end
                    if (o_pixel_inside !== exp_inside_q[0]) begin
                        $display("%0t: pixel_inside expected %0b actual %0b",
                                 $time, exp_inside_q[0], o_pixel_inside);
                        n_err++;
                    end
                    void'(exp_value_q.pop_front());
                    void'(exp_inside_q.pop_front());
                end
            end
        end
    end

    // watchdog, bounds the run even for a worst case line of 4096 steps at radius 15
    localparam longint CYCLE_LIMIT = 64'd60_000_000;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("thick_line_circle_brush_raster_core verification failed");
            $finish;
        end
    end

    initial begin
        int cmd_sel, sx, sy, ex, ey, r, color;
        n_err = 0;
        cycle = 0;
        out_idle_en = 1'b1;
        in_idle_en = 1'b1;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= CMD_SET_PIXEL;
        i_start_x <= '0;
        i_start_y <= '0;
        i_end_x <= '0;
        i_end_y <= '0;
        i_brush_radius <= '0;
        i_paint_color <= '0;
        for (int k = 0; k < PIXEL_COUNT; k++) shadow_frame[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; typed values cross-checked against the predictor
        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].cmd, dir_rows[k].sx, dir_rows[k].sy, dir_rows[k].ex,
                      dir_rows[k].ey, dir_rows[k].r, dir_rows[k].color);
            if (dir_rows[k].chk && (exp_value_q[$] !== 8'(dir_rows[k].val) ||
                                    exp_inside_q[$] !== 1'(dir_rows[k].ins))) begin
                $display("%0t: row %0d expected %0d/%0d predicted %0d/%0b", $time, k,
                         dir_rows[k].val, dir_rows[k].ins, exp_value_q[$], exp_inside_q[$]);
                n_err++;
            end
        end

        // hold off until every outstanding result is back
        i_valid <= 1'b0;
        while (exp_value_q.size() != 0) @(posedge i_clk);

        for (int n = 0; n < 700; n++) begin
            if (n == 600) begin
                in_idle_en = 1'b0;
                out_idle_en = 1'b0;
            end
            cmd_sel = $urandom_range(0, 9);
            sx = rand_coord();
            sy = rand_coord();
            ex = rand_coord();
            ey = rand_coord();
            // keep most lines of one of the two line selectors short so the run stays bounded
            if (cmd_sel == 4 && $urandom_range(0, 15) != 0) begin
                ex = sx + $urandom_range(0, 24) - 12;
                ey = sy + $urandom_range(0, 24) - 12;
            end
            r = $urandom_range(0, 9) == 0 ? $urandom_range(8, 15) : $urandom_range(0, 4);
            color = $urandom_range(0, 255);
            case (cmd_sel)
                0, 1:    send_beat(CMD_SET_PIXEL, sx, sy, ex, ey, r, color);
                2:       send_beat(CMD_FILL_DISC, sx, sy, ex, ey, r, color);
                3, 4:    send_beat(CMD_DRAW_LINE, sx, sy, ex, ey, $urandom_range(0, 3), color);
                default: send_beat(CMD_READ_PIX, sx, sy, ex, ey, r, color);
            endcase
        end

        i_valid <= 1'b0;
        while (exp_value_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_err == 0)
            $display("thick_line_circle_brush_raster_core verification clean");
        else
            $display("thick_line_circle_brush_raster_core verification failed");
        $finish;
    end
endmodule
